// ----- hdl/sledm_pkg.sv -----
// ----------------------------------------------------------------------------
// sledm_pkg
// Shared types, codes and lane helpers for the sized little-endian data memory.
// ----------------------------------------------------------------------------
`default_nettype none

package sledm_pkg;

    localparam int WORD_W   = 64;
    localparam int WORD_BYTES = WORD_W / 8;

    typedef logic [WORD_W-1:0] word_t;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // access size codes (bytes as a power of two)
    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_HALF  = 2'd1;
    localparam logic [1:0] SZ_WORD  = 2'd2;
    localparam logic [1:0] SZ_DWORD = 2'd3;

    // byte lane enables of one access, lowest byte in bit 0
    function automatic logic [WORD_BYTES-1:0] size_lanes(input logic [1:0] size);
        logic [WORD_BYTES-1:0] lanes;
        case (size)
            SZ_BYTE:  lanes = 8'h01;
            SZ_HALF:  lanes = 8'h03;
            SZ_WORD:  lanes = 8'h0F;
            SZ_DWORD: lanes = 8'hFF;
            default:  lanes = 8'h00;
        endcase
        return lanes;
    endfunction

    // widen a 16-lane enable into a 128-bit bit mask
    function automatic logic [2*WORD_W-1:0] lanes_to_bits(input logic [2*WORD_BYTES-1:0] lanes);
        logic [2*WORD_W-1:0] bits;
        for (int i = 0; i < 2*WORD_BYTES; i++) begin
            bits[8*i +: 8] = {8{lanes[i]}};
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sledm_bank.sv -----
// ----------------------------------------------------------------------------
// sledm_bank
// One bank of 64-bit rows: synchronous read with registered data, one write.
// ----------------------------------------------------------------------------
`default_nettype none

module sledm_bank #(
    parameter int ROWS  = 2,
    parameter int ROW_W = 1
) (
    input  wire                     aclk,
    input  wire                     rd_en,
    input  wire  [ROW_W-1:0]        rd_addr,
    output logic [sledm_pkg::WORD_W-1:0] rd_data,
    input  wire                     wr_en,
    input  wire  [ROW_W-1:0]        wr_addr,
    input  wire  [sledm_pkg::WORD_W-1:0] wr_data
);
    import sledm_pkg::*;

    word_t mem [ROWS];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/sized_little_endian_data_memory_top.sv -----
// ----------------------------------------------------------------------------
// sized_little_endian_data_memory_top
// Byte-addressed little-endian data memory, 1/2/4/8-byte loads and stores.
// ----------------------------------------------------------------------------
// Path: an accepted beat is captured in the access stage and bank read
//   registers; the result register then takes it once free, raising m_tvalid.
// Flow: no new beat is taken until the current access retires; the bank read
//   plus read-modify-write of the same rows occupies the access.
// Reset: aresetn (synchronous) starts a clearing pass that zeroes both banks;
//   s_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module sized_little_endian_data_memory_top #(
    parameter int MEM_BYTES = 65536
) (
    input  wire          aclk,
    input  wire          aresetn,
    // input beats
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [135:0] s_tdata,   // access_size[1:0], byte_address[65:2],
                                    // store_data[129:66], zero pad[135:130]
    input  wire  [0:0]   s_tuser,   // operation[0]
    // result beats
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [63:0]  m_tdata,   // load_data[63:0]
    output logic [0:0]   m_tuser    // range_error[0]
);
    import sledm_pkg::*;

    // Memory is split into two banks of 64-bit words: even words and odd
    // words. Any access touches word w and w+1 at most, one from each bank.
    localparam int WORDS = (MEM_BYTES + 7) / 8;
    localparam int ROWS  = WORDS / 2 + 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [ROW_W-1:0] clr_cnt_reg, clr_cnt_next;

    // ---------------- input decode ----------------
    logic        in_store;
    logic [1:0]  in_size;
    logic [63:0] in_addr;
    word_t       in_data;
    logic [3:0]  in_nbytes;
    logic        in_range;
    logic [ROW_W:0] in_word, in_word_inc;
    logic [ROW_W-1:0] in_even_row, in_odd_row;
    logic        s_beat;

    assign in_store = s_tuser[0];
    assign in_size  = s_tdata[1:0];
    assign in_addr  = s_tdata[65:2];
    assign in_data  = s_tdata[129:66];

    // Bound check without wraparound: last byte must lie below MEM_BYTES.
    assign in_nbytes = 4'd1 << in_size;
    assign in_range  = in_addr <= (64'(MEM_BYTES) - 64'(in_nbytes));

    // Word w lives in bank (w & 1) at row w >> 1; word w+1 in the other bank.
    assign in_word     = in_addr[ROW_W+3:3];
    assign in_word_inc = in_word + 1'b1;
    assign in_even_row = in_word_inc[ROW_W:1];
    assign in_odd_row  = in_word[ROW_W:1];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;

    // ---------------- access stage registers ----------------
    logic        st_store_reg;
    logic        st_err_reg;
    logic [1:0]  st_size_reg;
    logic [2:0]  st_ofs_reg;
    logic        st_odd_base_reg;
    word_t       st_data_reg;
    logic [ROW_W-1:0] st_even_row_reg, st_odd_row_reg;

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            st_store_reg    <= in_store;
            st_err_reg      <= !in_range;
            st_size_reg     <= in_size;
            st_ofs_reg      <= in_addr[2:0];
            st_odd_base_reg <= in_word[0];
            st_data_reg     <= in_data;
            st_even_row_reg <= in_even_row;
            st_odd_row_reg  <= in_odd_row;
        end
    end

    // ---------------- banks ----------------
    word_t even_q, odd_q;
    logic  bank_we;
    logic [ROW_W-1:0] even_wr_row, odd_wr_row;
    word_t even_wr_data, odd_wr_data;

    sledm_bank #(.ROWS(ROWS), .ROW_W(ROW_W)) u_even_bank (
        .aclk    (aclk),
        .rd_en   (s_beat),
        .rd_addr (in_even_row),
        .rd_data (even_q),
        .wr_en   (bank_we),
        .wr_addr (even_wr_row),
        .wr_data (even_wr_data)
    );

    sledm_bank #(.ROWS(ROWS), .ROW_W(ROW_W)) u_odd_bank (
        .aclk    (aclk),
        .rd_en   (s_beat),
        .rd_addr (in_odd_row),
        .rd_data (odd_q),
        .wr_en   (bank_we),
        .wr_addr (odd_wr_row),
        .wr_data (odd_wr_data)
    );

    // ---------------- read-modify-write ----------------
    word_t lo_word, hi_word;
    logic [2*WORD_W-1:0] window, shifted, wr_bits, wr_mask, merged;
    logic [2*WORD_BYTES-1:0] wr_lanes;
    logic [5:0] shamt;
    word_t load_val, lane_mask;
    logic  st_done;
    logic  clearing;

    // Order the two fetched words as (low, high) by the parity of word w.
    assign lo_word = st_odd_base_reg ? odd_q  : even_q;
    assign hi_word = st_odd_base_reg ? even_q : odd_q;
    assign window  = {hi_word, lo_word};
    assign shamt   = {st_ofs_reg, 3'b000};

    // Load: shift the addressed byte down to lane 0, drop bytes past the size.
    assign shifted   = window >> shamt;
    assign lane_mask = word_t'(lanes_to_bits({8'h00, size_lanes(st_size_reg)}));
    assign load_val  = shifted[WORD_W-1:0] & lane_mask;

    // Store: replace only the addressed byte lanes of the window.
    assign wr_lanes = {8'h00, size_lanes(st_size_reg)} << st_ofs_reg;
    assign wr_mask  = lanes_to_bits(wr_lanes);
    assign wr_bits  = {{WORD_W{1'b0}}, st_data_reg} << shamt;
    assign merged   = (window & ~wr_mask) | (wr_bits & wr_mask);

    // Retire the access once the result register can take it.
    assign st_done  = (state_reg == ST_BUSY) && (!m_tvalid || m_tready);
    assign clearing = (state_reg == ST_CLEAR);

    assign bank_we      = clearing || (st_done && st_store_reg && !st_err_reg);
    assign even_wr_row  = clearing ? clr_cnt_reg : st_even_row_reg;
    assign odd_wr_row   = clearing ? clr_cnt_reg : st_odd_row_reg;
    assign even_wr_data = clearing ? '0 :
                          (st_odd_base_reg ? merged[2*WORD_W-1:WORD_W] : merged[WORD_W-1:0]);
    assign odd_wr_data  = clearing ? '0 :
                          (st_odd_base_reg ? merged[WORD_W-1:0] : merged[2*WORD_W-1:WORD_W]);

    // ---------------- control ----------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_beat) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (st_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ---------------- result register ----------------
    logic  out_valid_reg;
    logic  out_err_reg;
    word_t out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st_done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_done) begin
            out_err_reg  <= st_err_reg;
            // zero for stores and out-of-range accesses
            out_data_reg <= (st_store_reg == OP_LOAD && !st_err_reg) ? load_val : '0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_err_reg;

    // ---------------- assertions ----------------
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> (state_reg == ST_BUSY))
        else $error("accepted beat did not start an access");

    a_hold_while_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUSY) && m_tvalid && !m_tready |=> (state_reg == ST_BUSY))
        else $error("access retired into a full result register");

    a_err_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0))
        else $error("range error result carries data");

    a_no_write_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        bank_we && !clearing |-> !st_err_reg && st_store_reg)
        else $error("bank written by a load or an out-of-range store");

    a_no_beat_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("input taken during clearing pass");

endmodule

`default_nettype wire
